/* design/meds_pkg.sv */
// Shared types and constants for the MIDI event delay scheduler.
`timescale 1ns / 1ps
package meds_pkg;
	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_BLOCK   = 8192;
	localparam int GAP_BITS    = 22;
	localparam int LEN_BITS    = 14;
	localparam int POS_BITS    = 13;
	localparam int NOTE_ROWS   = 16;
	localparam int NOTE_COLS   = 128;
	localparam int COUNT_BITS  = 12;

	localparam logic [1:0] CFG_DELAY      = 2'd0;
	localparam logic [1:0] CFG_LIKELIHOOD = 2'd1;
	localparam logic [1:0] CFG_POLYPHONY  = 2'd2;

	localparam logic [2:0] KIND_QUEUED   = 3'd0;
	localparam logic [2:0] KIND_CHANCE   = 3'd1;
	localparam logic [2:0] KIND_POLY     = 3'd2;
	localparam logic [2:0] KIND_FULL     = 3'd3;
	localparam logic [2:0] KIND_RELEASED = 3'd4;
	localparam logic [2:0] KIND_NONE     = 3'd5;

	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_NOTE_ON  = 4'h9;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
	} msg_t;

	// one queue slot: message and samples left until due
	typedef struct packed {
		logic                valid;
		msg_t                msg;
		logic [GAP_BITS-1:0] gap;
	} slot_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_AGE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t           cmd;
		slot_t               ins;
		logic [LEN_BITS-1:0] len;
	} cell_ctrl_t;

	typedef struct packed {
		logic rd;
		logic upd;
		msg_t msg;
	} note_req_t;
endpackage

/* design/meds_if.sv */
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
interface meds_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  status_byte;
	logic [6:0]  data_one;
	logic [6:0]  data_two;
	logic [12:0] sample_offset;
	logic [13:0] block_length;
	logic [15:0] random_draw;
	modport source (output valid, op, status_byte, data_one, data_two, sample_offset,
		block_length, random_draw, input ready);
	modport sink (input valid, op, status_byte, data_one, data_two, sample_offset,
		block_length, random_draw, output ready);
endinterface

interface meds_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_status;
	logic [6:0]  out_data_one;
	logic [6:0]  out_data_two;
	logic [12:0] block_position;
	logic        last;
	modport source (output valid, kind, out_status, out_data_one, out_data_two,
		block_position, last, input ready);
	modport sink (input valid, kind, out_status, out_data_one, out_data_two,
		block_position, last, output ready);
endinterface

/* design/midi_event_delay_scheduler_core.sv */
// Top level of the MIDI event delay scheduler.
// Channels: items (valid/ready) carry a message (op 0) or a block advance (op 1);
// results (valid/ready) carry one beat per message, one or more per advance,
// with last set on the final beat of an item. cfg_we/cfg_index/cfg_wdata write
// delay_samples, likelihood_percent and max_polyphony; write only while idle.
// A message loads its result beat in S_MSG once the result register is free,
// then returns to S_IDLE to accept the next item. An advance checks the queue
// head (S_ADV), then for each released message reads its bitmap row (S_READ)
// and releases it with bitmap write and queue shift (S_REL), and then ages the
// queue (S_AGE); with nothing due it presents the empty beat (S_NONE) before
// aging instead.
// One item is in work at a time.
// The queue is a chain of 64 cells kept sorted by samples left until due;
// inserting and shifting move all cells at once.
// Reset empties the queue and restores register defaults;
// after reset the note bitmap memory is cleared one row per cycle, all 16 rows,
// during which no item is accepted.
// A stalled receiver holds the result register; the block waits with it.
`timescale 1ns / 1ps
module midi_event_delay_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_wdata,
	meds_in_if.sink     items,
	meds_out_if.source  results
);
	typedef enum logic [2:0] {
		S_IDLE, S_MSG, S_ADV, S_READ, S_REL, S_NONE, S_AGE
	} state_t;

	state_t state_q;
	logic [20:0] delay_q;
	logic [6:0]  lik_q;
	logic [7:0]  poly_q;

	meds_pkg::msg_t              msg_s1;
	logic [12:0]                 off_s1;
	logic [15:0]                 draw_s1;
	logic [meds_pkg::LEN_BITS-1:0] len_s1;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	meds_pkg::msg_t out_msg_q;
	logic [12:0] pos_q;
	logic        last_q;

	meds_pkg::slot_t slots [meds_pkg::QUEUE_DEPTH];
	logic            gts   [meds_pkg::QUEUE_DEPTH];
	meds_pkg::cell_ctrl_t ctrl;
	meds_pkg::note_req_t  nreq;
	logic        notes_busy;
	logic [meds_pkg::COUNT_BITS-1:0] active_count;

	logic out_free;
	logic beat_load;
	logic is_on;
	logic poly_drop;
	logic chance_drop;
	logic full;
	logic head_due;
	logic next_due;
	logic [meds_pkg::GAP_BITS-1:0] len_w;
	logic [meds_pkg::LEN_BITS-1:0] len_in;

	assign out_free = !out_valid_q || results.ready;
	assign beat_load = out_free && (state_q == S_MSG || state_q == S_REL || state_q == S_NONE);
	assign items.ready = state_q == S_IDLE && !notes_busy;

	assign results.valid          = out_valid_q;
	assign results.kind           = kind_q;
	assign results.out_status     = out_msg_q.status_byte;
	assign results.out_data_one   = out_msg_q.data_one;
	assign results.out_data_two   = out_msg_q.data_two;
	assign results.block_position = pos_q;
	assign results.last           = last_q;

	assign is_on = msg_s1.status_byte[7:4] == meds_pkg::HI_NOTE_ON && msg_s1.data_two != 7'd0;
	assign poly_drop = is_on &&
		({{(meds_pkg::COUNT_BITS - 8){1'b0}}, poly_q} <= active_count);
	assign chance_drop = (23'(draw_s1) * 23'd100) > (23'(lik_q) * 23'd65535);
	assign full = slots[meds_pkg::QUEUE_DEPTH-1].valid;
	assign len_w = {{(meds_pkg::GAP_BITS - meds_pkg::LEN_BITS){1'b0}}, len_s1};
	assign head_due = slots[0].valid && slots[0].gap < len_w;
	assign next_due = slots[1].valid && slots[1].gap < len_w;
	assign len_in = (items.block_length > meds_pkg::LEN_BITS'(meds_pkg::MAX_BLOCK)) ?
		meds_pkg::LEN_BITS'(meds_pkg::MAX_BLOCK) : items.block_length;

	always_comb begin
		ctrl.cmd       = meds_pkg::CELL_HOLD;
		ctrl.ins.valid = 1'b1;
		ctrl.ins.msg   = msg_s1;
		ctrl.ins.gap   = meds_pkg::GAP_BITS'(off_s1) + meds_pkg::GAP_BITS'(delay_q);
		ctrl.len       = len_s1;
		nreq.rd  = 1'b0;
		nreq.upd = 1'b0;
		nreq.msg = slots[0].msg;
		unique case (state_q)
			S_MSG: begin
				if (out_free && !poly_drop && !chance_drop && !full)
					ctrl.cmd = meds_pkg::CELL_INSERT;
			end
			S_READ: nreq.rd = 1'b1;
			S_REL: begin
				if (out_free) begin
					ctrl.cmd = meds_pkg::CELL_SHIFT;
					nreq.upd = 1'b1;
				end
			end
			S_AGE: ctrl.cmd = meds_pkg::CELL_AGE;
			default: ;
		endcase
	end

	for (genvar i = 0; i < meds_pkg::QUEUE_DEPTH; i++) begin : g_chain
		meds_pkg::slot_t left_c;
		meds_pkg::slot_t right_c;
		logic            left_gt_c;
		if (i == 0) begin : g_first
			assign left_c    = '0;
			assign left_gt_c = 1'b0;
		end else begin : g_mid
			assign left_c    = slots[i-1];
			assign left_gt_c = gts[i-1];
		end
		if (i == meds_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign right_c = '0;
		end else begin : g_inner
			assign right_c = slots[i+1];
		end
		meds_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (left_c),
			.left_gt (left_gt_c),
			.right   (right_c),
			.slot    (slots[i]),
			.gt      (gts[i])
		);
	end

	meds_notes u_notes (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (nreq),
		.busy         (notes_busy),
		.active_count (active_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			delay_q     <= '0;
			lik_q       <= 7'd100;
			poly_q      <= 8'd128;
			out_valid_q <= 1'b0;
			kind_q      <= '0;
			out_msg_q   <= '0;
			pos_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					meds_pkg::CFG_DELAY:      delay_q <= cfg_wdata;
					meds_pkg::CFG_LIKELIHOOD: lik_q   <= cfg_wdata[6:0];
					meds_pkg::CFG_POLYPHONY:  poly_q  <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (beat_load) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (items.valid && items.ready) state_q <= items.op ? S_ADV : S_MSG;
				end
				S_MSG: begin
					if (out_free) begin
						out_msg_q   <= '0;
						pos_q       <= '0;
						last_q      <= 1'b1;
						if (poly_drop) kind_q <= meds_pkg::KIND_POLY;
						else if (chance_drop) kind_q <= meds_pkg::KIND_CHANCE;
						else if (full) kind_q <= meds_pkg::KIND_FULL;
						else kind_q <= meds_pkg::KIND_QUEUED;
						state_q <= S_IDLE;
					end
				end
				S_ADV: state_q <= head_due ? S_READ : S_NONE;
				S_READ: state_q <= S_REL;
				S_REL: begin
					if (out_free) begin
						kind_q      <= meds_pkg::KIND_RELEASED;
						out_msg_q   <= slots[0].msg;
						pos_q       <= slots[0].gap[12:0];
						last_q      <= !next_due;
						state_q     <= next_due ? S_READ : S_AGE;
					end
				end
				S_NONE: begin
					if (out_free) begin
						kind_q      <= meds_pkg::KIND_NONE;
						out_msg_q   <= '0;
						pos_q       <= '0;
						last_q      <= 1'b1;
						state_q     <= S_AGE;
					end
				end
				S_AGE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the accepted item for the following states
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			msg_s1.status_byte <= items.status_byte;
			msg_s1.data_one    <= items.data_one;
			msg_s1.data_two    <= items.data_two;
			off_s1             <= items.sample_offset;
			draw_s1            <= items.random_draw;
			len_s1             <= items.op ? len_in : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		slots[1].valid |-> (slots[0].valid && slots[0].gap <= slots[1].gap))
		else $error("queue head out of order");
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		notes_busy |-> !items.ready)
		else $error("item accepted during bitmap clear");
	a_release_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL && out_free) |-> head_due)
		else $error("release of a message not due");
	a_age_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AGE |-> (out_valid_q && last_q))
		else $error("aging without final result beat");
`endif
endmodule

/* design/meds_cell.sv */
// One slot of the sorted delay queue.
`timescale 1ns / 1ps
module meds_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  meds_pkg::cell_ctrl_t ctrl,
	input  meds_pkg::slot_t     left,
	input  logic                left_gt,
	input  meds_pkg::slot_t     right,
	output meds_pkg::slot_t     slot,
	output logic                gt
);
	logic                          valid_q;
	meds_pkg::msg_t                msg_q;
	logic [meds_pkg::GAP_BITS-1:0] gap_q;

	// new item goes in front of the first empty or later slot
	assign gt   = !valid_q || (gap_q > ctrl.ins.gap);
	assign slot = '{valid_q, msg_q, gap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctrl.cmd)
				meds_pkg::CELL_HOLD: ;
				meds_pkg::CELL_INSERT: begin
					if (gt) valid_q <= left_gt ? left.valid : ctrl.ins.valid;
				end
				meds_pkg::CELL_SHIFT: valid_q <= right.valid;
				meds_pkg::CELL_AGE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			meds_pkg::CELL_HOLD: ;
			meds_pkg::CELL_INSERT: begin
				if (gt) begin
					msg_q <= left_gt ? left.msg : ctrl.ins.msg;
					gap_q <= left_gt ? left.gap : ctrl.ins.gap;
				end
			end
			meds_pkg::CELL_SHIFT: begin
				msg_q <= right.msg;
				gap_q <= right.gap;
			end
			meds_pkg::CELL_AGE: begin
				gap_q <= gap_q -
					{{(meds_pkg::GAP_BITS - meds_pkg::LEN_BITS){1'b0}}, ctrl.len};
			end
			default: ;
		endcase
	end
endmodule

/* design/meds_notes.sv */
// Active-note bitmap in a row memory with a clearing pass, plus active count.
`timescale 1ns / 1ps
module meds_notes (
	input  logic                                clk,
	input  logic                                arst_n,
	input  meds_pkg::note_req_t                 req,
	output logic                                busy,
	output logic [meds_pkg::COUNT_BITS-1:0]     active_count
);
	logic [meds_pkg::NOTE_COLS-1:0] mem [meds_pkg::NOTE_ROWS];
	logic [meds_pkg::NOTE_COLS-1:0] row_q;
	logic [4:0]                     clr_q;
	logic [meds_pkg::COUNT_BITS-1:0] count_q;
	logic [3:0]                     row_idx;
	logic                           is_on;
	logic                           is_off;
	logic                           bit_now;
	logic [meds_pkg::NOTE_COLS-1:0] row_new;

	assign busy         = !clr_q[4];
	assign active_count = count_q;
	assign row_idx      = req.msg.status_byte[3:0];
	assign is_on  = req.msg.status_byte[7:4] == meds_pkg::HI_NOTE_ON &&
		req.msg.data_two != 7'd0;
	assign is_off = !is_on && (req.msg.status_byte[7:4] == meds_pkg::HI_NOTE_ON ||
		req.msg.status_byte[7:4] == meds_pkg::HI_NOTE_OFF);
	assign bit_now = row_q[req.msg.data_one];

	always_comb begin
		row_new = row_q;
		if (is_on) row_new[req.msg.data_one] = 1'b1;
		else if (is_off) row_new[req.msg.data_one] = 1'b0;
	end

	// zero one row per cycle after reset, and keep the active-note count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			if (busy) clr_q <= clr_q + 5'd1;
			if (req.upd) begin
				if (is_on && !bit_now) count_q <= count_q + 1'b1;
				else if (is_off && bit_now) count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy) mem[clr_q[3:0]] <= '0;
		else if (req.upd) mem[row_idx] <= row_new;
		if (req.rd) row_q <= mem[row_idx];
	end
endmodule

/* tb/tb_midi_event_delay_scheduler_core.sv */
// Self-checking testbench for the MIDI event delay scheduler core.
`timescale 1ns / 1ps
module tb_midi_event_delay_scheduler_core;
	localparam int         WATCH_LIMIT = 3000;
	localparam int         HOLD_CYCLES = 300;
	localparam logic [1:0] OP_MSG      = 2'd0;
	localparam logic [1:0] OP_ADVANCE  = 2'd1;

	typedef struct packed {
		logic        op;
		logic [7:0]  st;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [12:0] off;
		logic [13:0] len;
		logic [15:0] draw;
	} event_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  st;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [12:0] pos;
		logic        last;
	} beat_t;

	typedef struct {
		event_t      ev;
		bit          typed;
		logic [2:0]  kind;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [20:0] cfg_wdata;

	meds_in_if  items ();
	meds_out_if results ();

	midi_event_delay_scheduler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.items     (items.sink),
		.results   (results.source)
	);

	// scheduler state as the block should hold it
	logic [20:0]    delay_now;
	logic [6:0]     chance_pct;
	logic [7:0]     poly_limit;
	logic [47:0]    now_clock;
	meds_pkg::msg_t pend_msg [meds_pkg::QUEUE_DEPTH];
	logic [47:0]    pend_due [meds_pkg::QUEUE_DEPTH];
	int             pend_fill;
	bit             key_on [2048];
	int             keys_held;

	beat_t       due_beats [$];
	int          errors, n_events, n_beats, n_released, n_full, n_poly;
	int          idle_cycles;
	bit          steady, hold_req;
	row_t        rows [$];

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic row_t mk_row(logic op, logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
		logic [12:0] off, logic [13:0] len, logic [15:0] draw, bit typed, logic [2:0] kind);
		row_t r;
		r.ev = '{op, st, d1, d2, off, len, draw};
		r.typed = typed;
		r.kind = kind;
		return r;
	endfunction

	function automatic void track_key(meds_pkg::msg_t m);
		logic [10:0] key;
		key = {m.status_byte[3:0], m.data_one};
		if (m.status_byte[7:4] == meds_pkg::HI_NOTE_ON && m.data_two != 0) begin
			if (!key_on[key]) begin
				key_on[key] = 1'b1;
				keys_held++;
			end
		end else if (m.status_byte[7:4] == meds_pkg::HI_NOTE_OFF ||
			m.status_byte[7:4] == meds_pkg::HI_NOTE_ON) begin
			if (key_on[key]) begin
				key_on[key] = 1'b0;
				keys_held--;
			end
		end
	endfunction

	// schedule one event and return the beats it should produce
	task automatic schedule_event(input event_t ev, output beat_t outs [$]);
		logic [47:0] sign, d, k, best_k;
		logic [13:0] ln;
		logic [2:0]  kind;
		logic [12:0] pos;
		bit          on;
		int          best;
		outs = {};
		sign = 48'h8000_0000_0000;
		if (ev.op == OP_MSG[0]) begin
			on = ev.st[7:4] == meds_pkg::HI_NOTE_ON && ev.d2 != 0;
			if (on && keys_held >= poly_limit)
				kind = meds_pkg::KIND_POLY;
			else if (64'(ev.draw) * 100 > 64'(chance_pct) * 65535)
				kind = meds_pkg::KIND_CHANCE;
			else if (pend_fill >= meds_pkg::QUEUE_DEPTH)
				kind = meds_pkg::KIND_FULL;
			else begin
				pend_msg[pend_fill] = '{ev.st, ev.d1, ev.d2};
				pend_due[pend_fill] = now_clock + 48'(ev.off) + 48'(delay_now);
				pend_fill++;
				kind = meds_pkg::KIND_QUEUED;
			end
			outs.push_back('{kind, 8'd0, 7'd0, 7'd0, 13'd0, 1'b1});
		end else begin
			ln = ev.len > meds_pkg::MAX_BLOCK ? 14'(meds_pkg::MAX_BLOCK) : ev.len;
			while (pend_fill > 0 && outs.size() < 64) begin
				best = 0;
				best_k = (pend_due[0] - now_clock) ^ sign;
				for (int i = 1; i < pend_fill; i++) begin
					k = (pend_due[i] - now_clock) ^ sign;
					if (k < best_k) begin
						best_k = k;
						best = i;
					end
				end
				d = pend_due[best] - now_clock;
				if (d[47])
					pos = '0;
				else if (d < 48'(ln))
					pos = d > 48'd8191 ? 13'd8191 : d[12:0];
				else
					break;
				outs.push_back('{meds_pkg::KIND_RELEASED, pend_msg[best].status_byte,
					pend_msg[best].data_one, pend_msg[best].data_two, pos, 1'b0});
				track_key(pend_msg[best]);
				for (int i = best; i + 1 < pend_fill; i++) begin
					pend_msg[i] = pend_msg[i + 1];
					pend_due[i] = pend_due[i + 1];
				end
				pend_fill--;
			end
			if (outs.size() == 0)
				outs.push_back('{meds_pkg::KIND_NONE, 8'd0, 7'd0, 7'd0, 13'd0, 1'b1});
			else
				outs[outs.size() - 1].last = 1'b1;
			now_clock = now_clock + 48'(ln);
		end
	endtask

	task automatic send_event(input event_t ev, input bit typed, input logic [2:0] kind);
		beat_t outs [$];
		while (!steady && $urandom_range(99) < 36) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid         <= 1'b1;
		items.op            <= ev.op;
		items.status_byte   <= ev.st;
		items.data_one      <= ev.d1;
		items.data_two      <= ev.d2;
		items.sample_offset <= ev.off;
		items.block_length  <= ev.len;
		items.random_draw   <= ev.draw;
		do
			@(posedge clk);
		while (!items.ready);
		schedule_event(ev, outs);
		// a typed row overrides the single beat with the value read off by hand
		if (typed)
			outs[0] = '{kind, 8'd0, 7'd0, 7'd0, 13'd0, 1'b1};
		foreach (outs[i])
			due_beats.push_back(outs[i]);
		n_events++;
	endtask

	task automatic drain();
		items.valid <= 1'b0;
		wait (due_beats.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input logic [20:0] dly, input logic [6:0] pct, input logic [7:0] pol);
		cfg_we <= 1'b1;
		cfg_index <= meds_pkg::CFG_DELAY;
		cfg_wdata <= dly;
		@(posedge clk);
		cfg_index <= meds_pkg::CFG_LIKELIHOOD;
		cfg_wdata <= 21'(pct);
		@(posedge clk);
		cfg_index <= meds_pkg::CFG_POLYPHONY;
		cfg_wdata <= 21'(pol);
		@(posedge clk);
		cfg_we <= 1'b0;
		delay_now = dly;
		chance_pct = pct;
		poly_limit = pol;
	endtask

	task automatic random_events(input int count);
		event_t ev;
		int     sel;
		repeat (count) begin
			ev = '0;
			ev.draw = 16'($urandom_range(65535));
			if ($urandom_range(99) < 25) begin
				ev.op = OP_ADVANCE[0];
				sel = $urandom_range(9);
				if (sel == 0)
					ev.len = '0;
				else if (sel == 1)
					ev.len = 14'($urandom_range(16383, 8192));
				else
					ev.len = 14'($urandom_range(8192, 1));
				ev.st = 8'($urandom_range(255));
			end else begin
				ev.op = OP_MSG[0];
				if ($urandom_range(99) < 70) begin
					ev.st = {($urandom_range(1) ? meds_pkg::HI_NOTE_ON : meds_pkg::HI_NOTE_OFF),
						4'($urandom_range(1))};
					ev.d1 = 7'($urandom_range(63, 60));
				end else begin
					ev.st = 8'($urandom_range(255));
					ev.d1 = 7'($urandom_range(127));
				end
				ev.d2 = $urandom_range(99) < 15 ? 7'd0 : 7'($urandom_range(127));
				sel = $urandom_range(9);
				ev.off = sel == 0 ? 13'd0 : sel == 1 ? 13'd8191 : 13'($urandom_range(8191));
				ev.len = 14'($urandom_range(16383));
			end
			send_event(ev, 1'b0, meds_pkg::KIND_QUEUED);
		end
	endtask

	task automatic check_field(input string name, input logic [12:0] want, input logic [12:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// compare each result beat with the oldest outstanding one
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && results.valid && results.ready) begin
			n_beats++;
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got kind %0d", $time,
					results.kind);
				errors++;
			end else begin
				want = due_beats.pop_front();
				check_field("kind", 13'(want.kind), 13'(results.kind));
				check_field("out_status", 13'(want.st), 13'(results.out_status));
				check_field("out_data_one", 13'(want.d1), 13'(results.out_data_one));
				check_field("out_data_two", 13'(want.d2), 13'(results.out_data_two));
				check_field("block_position", want.pos, results.block_position);
				check_field("last", 13'(want.last), 13'(results.last));
				if (want.kind == meds_pkg::KIND_RELEASED)
					n_released++;
				if (want.kind == meds_pkg::KIND_FULL)
					n_full++;
				if (want.kind == meds_pkg::KIND_POLY)
					n_poly++;
			end
		end
	end

	initial begin
		results.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			results.ready <= steady || $urandom_range(99) >= 36;
		end
	end

	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("%0t: watchdog expired with %0d beats outstanding", $time, due_beats.size());
			$display("tb_midi_event_delay_scheduler_core: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = meds_pkg::CFG_DELAY;
		cfg_wdata = '0;
		items.valid = 1'b0;
		items.op = 1'b0;
		items.status_byte = '0;
		items.data_one = '0;
		items.data_two = '0;
		items.sample_offset = '0;
		items.block_length = '0;
		items.random_draw = '0;
		errors = 0;
		n_events = 0;
		n_beats = 0;
		n_released = 0;
		n_full = 0;
		n_poly = 0;
		idle_cycles = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		delay_now = '0;
		chance_pct = 7'd100;
		poly_limit = 8'd128;
		now_clock = '0;
		pend_fill = 0;
		keys_held = 0;
		foreach (key_on[i])
			key_on[i] = 1'b0;

		rows.push_back(mk_row(1'b1, 8'h00, 7'd0, 7'd0, 13'd0, 14'd0, 16'd0, 1,
			meds_pkg::KIND_NONE));
		rows.push_back(mk_row(1'b0, 8'h90, 7'd60, 7'd100, 13'd0, 14'd0, 16'd0, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b0, 8'hFF, 7'd127, 7'd127, 13'd8191, 14'd0, 16'hFFFF, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b0, 8'h95, 7'd60, 7'd0, 13'd0, 14'd0, 16'd1, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b0, 8'h80, 7'd60, 7'd64, 13'd2, 14'd0, 16'd500, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b0, 8'h90, 7'd60, 7'd90, 13'd1, 14'd0, 16'd7, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b0, 8'hC3, 7'd5, 7'd0, 13'd1, 14'd0, 16'd9, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b1, 8'h00, 7'd0, 7'd0, 13'd0, 14'd0, 16'd0, 0,
			meds_pkg::KIND_NONE));
		rows.push_back(mk_row(1'b1, 8'h00, 7'd0, 7'd0, 13'd0, 14'd1, 16'd0, 0,
			meds_pkg::KIND_NONE));
		rows.push_back(mk_row(1'b1, 8'h00, 7'd0, 7'd0, 13'd0, 14'd2, 16'd0, 0,
			meds_pkg::KIND_NONE));
		rows.push_back(mk_row(1'b0, 8'h9F, 7'd127, 7'd1, 13'd100, 14'd0, 16'd0, 1,
			meds_pkg::KIND_QUEUED));
		rows.push_back(mk_row(1'b1, 8'h00, 7'd0, 7'd0, 13'd0, 14'd16383, 16'd0, 0,
			meds_pkg::KIND_NONE));
		rows.push_back(mk_row(1'b1, 8'h00, 7'd0, 7'd0, 13'd0, 14'd8192, 16'd0, 1,
			meds_pkg::KIND_NONE));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_event(rows[i].ev, rows[i].typed, rows[i].kind);
		random_events(30);
		drain();

		// long run with no idling on either side
		set_regs(21'd100, 7'd50, 8'd4);
		steady = 1'b1;
		random_events(30);
		steady = 1'b0;
		drain();

		// pass everything, drop every note-on; stall the receiver while items keep coming
		set_regs(21'd5000, 7'd127, 8'd0);
		hold_req = 1'b1;
		random_events(30);
		drain();

		set_regs(21'd1, 7'd0, 8'd255);
		random_events(20);
		drain();

		// far-off due times fill the queue
		set_regs(21'd1920000, 7'd100, 8'd255);
		random_events(100);
		drain();

		$display("covered %0d items and %0d beats: %0d released, %0d queue full, %0d polyphony drops",
			n_events, n_beats, n_released, n_full, n_poly);
		if (errors == 0)
			$display("tb_midi_event_delay_scheduler_core: clean");
		else
			$display("tb_midi_event_delay_scheduler_core: errors");
		$finish;
	end
endmodule

/* filelist.f */
design/meds_pkg.sv
design/meds_if.sv
design/meds_cell.sv
design/meds_notes.sv
design/midi_event_delay_scheduler_core.sv
tb/tb_midi_event_delay_scheduler_core.sv
